FILE: hw/rtl/sbfq_pkg.sv
`default_nettype none

package sbfq_pkg;

	localparam logic [2:0] OP_PUSH  = 3'd0;
	localparam logic [2:0] OP_POP   = 3'd1;
	localparam logic [2:0] OP_FRONT = 3'd2;
	localparam logic [2:0] OP_FLUSH = 3'd3;
	localparam logic [2:0] OP_QUERY = 3'd4;

	typedef struct packed {
		logic [2:0]  operation;
		logic [31:0] address;
		logic [31:0] store_value;
		logic [3:0]  rob_index;
	} req_t;

	typedef struct packed {
		logic        hit;
		logic [31:0] out_address;
		logic [31:0] out_data;
		logic [3:0]  out_rob_index;
	} rsp_t;

	typedef struct packed {
		logic [31:0] address;
		logic [31:0] data;
		logic [3:0]  rob;
	} slot_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_HEAD,
		ST_WALK
	} state_t;

endpackage

`default_nettype wire

FILE: hw/rtl/store_buffer_forwarding_queue.sv
`default_nettype none

// Store buffer with store-to-load forwarding, DEPTH slots in a circular queue.
// Raise start with a command on req while busy is low; the beat is taken at
// that edge. Every command yields exactly one result: done is high for one
// cycle with the result on result, and the receiver cannot hold it off.
// Push, flush and unused codes: done the cycle after the command, busy stays
// low, so one of these can be issued every cycle.
// Pop and front: one slot read from the slot RAM; the RAM registers the slot,
// then done and result are registered, and busy is high while in ST_HEAD.
// Query: walks the slots from the newest back to the head, one RAM read and
// one word-address compare per cycle. The walk stops at the first valid
// match or after the head slot, so at most DEPTH slots are checked; the
// single read port of the slot RAM is why the slots are read one at a time.
// Reset clears every valid mark and both pointers at once; slot contents are
// left as they are and may be read unwritten, but only a valid slot can hit.
module store_buffer_forwarding_queue #(
	parameter int DEPTH = 16
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         start,
	input  wire sbfq_pkg::req_t req,
	output      logic         busy,
	output      logic         done,
	output      sbfq_pkg::rsp_t result
);

	localparam int AW = $clog2(DEPTH);
	localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

	sbfq_pkg::state_t state_q, state_d;

	logic [AW-1:0]    wptr_q, rptr_q, walk_q;
	logic [DEPTH-1:0] valid_q;
	logic             pop_q;
	logic [29:0]      qword_q;
	logic             done_q, done_d;
	sbfq_pkg::rsp_t   result_q, result_d;

	logic [AW-1:0]  wptr_prev, wptr_next, rptr_next, walk_prev, raddr;
	logic           ram_we, accept, walk_go;
	sbfq_pkg::slot_t wslot, rslot;

	assign wptr_prev = (wptr_q == '0) ? LAST : wptr_q - AW'(1);
	assign wptr_next = (wptr_q == LAST) ? '0 : wptr_q + AW'(1);
	assign rptr_next = (rptr_q == LAST) ? '0 : rptr_q + AW'(1);
	assign walk_prev = (walk_q == '0) ? LAST : walk_q - AW'(1);

	assign accept = start && (state_q == sbfq_pkg::ST_IDLE);

	assign wslot.address = req.address;
	assign wslot.data    = req.store_value;
	assign wslot.rob     = req.rob_index;

	sbfq_ram #(
		.WIDTH($bits(sbfq_pkg::slot_t)),
		.DEPTH(DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(wptr_q),
		.wdata(wslot),
		.raddr(raddr),
		.rdata(rslot)
	);

	always_comb begin
		state_d  = state_q;
		raddr    = walk_prev;
		ram_we   = 1'b0;
		done_d   = 1'b0;
		result_d = '0;
		walk_go  = 1'b0;
		case (state_q)
			sbfq_pkg::ST_IDLE: begin
				if (start) begin
					case (req.operation)
						sbfq_pkg::OP_PUSH: begin
							ram_we = 1'b1;
							done_d = 1'b1;
						end
						sbfq_pkg::OP_POP, sbfq_pkg::OP_FRONT: begin
							raddr   = rptr_q;
							state_d = sbfq_pkg::ST_HEAD;
						end
						sbfq_pkg::OP_QUERY: begin
							raddr   = wptr_prev;
							state_d = sbfq_pkg::ST_WALK;
						end
						default: begin
							done_d = 1'b1;
						end
					endcase
				end
			end
			sbfq_pkg::ST_HEAD: begin
				done_d                 = 1'b1;
				result_d.hit           = valid_q[rptr_q];
				result_d.out_address   = rslot.address;
				result_d.out_data      = rslot.data;
				result_d.out_rob_index = rslot.rob;
				state_d                = sbfq_pkg::ST_IDLE;
			end
			sbfq_pkg::ST_WALK: begin
				if (valid_q[walk_q] && (rslot.address[31:2] == qword_q)) begin
					done_d            = 1'b1;
					result_d.hit      = 1'b1;
					result_d.out_data = rslot.data;
					state_d           = sbfq_pkg::ST_IDLE;
				end else if (walk_q == rptr_q) begin
					// head checked without a match: miss
					done_d  = 1'b1;
					state_d = sbfq_pkg::ST_IDLE;
				end else begin
					walk_go = 1'b1;
				end
			end
			default: begin
				state_d = sbfq_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sbfq_pkg::ST_IDLE;
			done_q  <= 1'b0;
			wptr_q  <= '0;
			rptr_q  <= '0;
			valid_q <= '0;
		end else begin
			state_q <= state_d;
			done_q  <= done_d;
			if (accept && (req.operation == sbfq_pkg::OP_PUSH)) begin
				valid_q[wptr_q] <= 1'b1;
				wptr_q          <= wptr_next;
			end
			if (accept && (req.operation == sbfq_pkg::OP_FLUSH)) begin
				valid_q <= '0;
				wptr_q  <= '0;
				rptr_q  <= '0;
			end
			if ((state_q == sbfq_pkg::ST_HEAD) && pop_q) begin
				valid_q[rptr_q] <= 1'b0;
				rptr_q          <= rptr_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		result_q <= result_d;
		if (accept) begin
			pop_q   <= (req.operation == sbfq_pkg::OP_POP);
			qword_q <= req.address[31:2];
			walk_q  <= wptr_prev;
		end else if (walk_go) begin
			walk_q <= walk_prev;
		end
	end

	assign busy   = (state_q != sbfq_pkg::ST_IDLE);
	assign done   = done_q;
	assign result = result_q;

endmodule

`default_nettype wire

FILE: hw/rtl/sbfq_ram.sv
`default_nettype none

module sbfq_ram #(
	parameter int WIDTH = 68,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

FILE: verif/testbench.sv
`default_nettype none

module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import sbfq_pkg::*;

	localparam int DEPTH = 16;
	localparam int CLK_PERIOD = 10;
	localparam int STALL_LIMIT = 2000;
	localparam int SETTLE_CYCLES = DEPTH + 8;
	localparam logic [31:0] WORD_MASK = 32'hFFFF_FFFC;
	localparam logic [2:0] OP_SPARE_FIRST = 3'd5;
	localparam logic [2:0] OP_SPARE_LAST = 3'd7;

	logic clk = 1'b0;
	logic arst_n;
	logic start;
	req_t req_bus;
	logic busy;
	logic done;
	rsp_t result_bus;

	store_buffer_forwarding_queue #(.DEPTH(DEPTH)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.req(req_bus),
		.busy(busy),
		.done(done),
		.result(result_bus)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// Shadow copy of the store buffer
	logic [31:0] sb_addr [DEPTH];
	logic [31:0] sb_data [DEPTH];
	logic [3:0]  sb_rob [DEPTH];
	logic        sb_valid [DEPTH];
	int          wr_ptr;
	int          rd_ptr;

	rsp_t pending_rsp [$];

	int error_count = 0;
	int beats_sent = 0;
	int results_seen = 0;
	int stall_cycles = 0;
	int query_hits = 0;
	int query_misses = 0;
	int full_pushes = 0;
	int empty_pops = 0;
	bit idle_enable = 1'b1;

	function automatic int prev_slot(input int p);
		return (p == 0) ? DEPTH - 1 : p - 1;
	endfunction

	function automatic rsp_t apply_store_op(input req_t r);
		rsp_t rsp;
		int p;
		int i;
		bit stop;
		rsp = '0;
		case (r.operation)
			OP_PUSH: begin
				if (sb_valid[wr_ptr])
					full_pushes++;
				sb_addr[wr_ptr] = r.address;
				sb_data[wr_ptr] = r.store_value;
				sb_rob[wr_ptr] = r.rob_index;
				sb_valid[wr_ptr] = 1'b1;
				wr_ptr = (wr_ptr + 1) % DEPTH;
			end
			OP_POP, OP_FRONT: begin
				rsp.hit = sb_valid[rd_ptr];
				rsp.out_address = sb_addr[rd_ptr];
				rsp.out_data = sb_data[rd_ptr];
				rsp.out_rob_index = sb_rob[rd_ptr];
				if (r.operation == OP_POP) begin
					if (!sb_valid[rd_ptr])
						empty_pops++;
					sb_valid[rd_ptr] = 1'b0;
					rd_ptr = (rd_ptr + 1) % DEPTH;
				end
			end
			OP_FLUSH: begin
				for (i = 0; i < DEPTH; i++)
					sb_valid[i] = 1'b0;
				wr_ptr = 0;
				rd_ptr = 0;
			end
			OP_QUERY: begin
				// walk newest to head, stop after the head slot
				p = prev_slot(wr_ptr);
				stop = 1'b0;
				for (i = 0; i < DEPTH && !stop; i++) begin
					if (sb_valid[p] && (sb_addr[p] & WORD_MASK) == (r.address & WORD_MASK)) begin
						rsp.hit = 1'b1;
						rsp.out_data = sb_data[p];
						stop = 1'b1;
					end else if (p == rd_ptr) begin
						stop = 1'b1;
					end else begin
						p = prev_slot(p);
					end
				end
				if (rsp.hit)
					query_hits++;
				else
					query_misses++;
			end
			default: ;
		endcase
		return rsp;
	endfunction

	function automatic req_t make_req(input logic [2:0] op, input logic [31:0] addr,
			input logic [31:0] value, input logic [3:0] rob);
		req_t r;
		r.operation = op;
		r.address = addr;
		r.store_value = value;
		r.rob_index = rob;
		return r;
	endfunction

	// Mostly a small pool of word addresses so queries alias with pushes
	function automatic logic [31:0] pick_address();
		logic [31:0] a;
		a = $urandom();
		if ($urandom_range(0, 9) < 7)
			a = 32'h0000_1000 + ($urandom_range(0, 7) << 2) + $urandom_range(0, 3);
		return a;
	endfunction

	function automatic req_t random_store_op();
		req_t r;
		int roll;
		r = make_req(OP_QUERY, pick_address(), $urandom(), 4'($urandom_range(0, 15)));
		roll = $urandom_range(0, 99);
		if (roll < 35)
			r.operation = OP_PUSH;
		else if (roll < 55)
			r.operation = OP_POP;
		else if (roll < 65)
			r.operation = OP_FRONT;
		else if (roll < 93)
			r.operation = OP_QUERY;
		else if (roll < 96)
			r.operation = OP_FLUSH;
		else
			r.operation = 3'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST));
		// keep most traffic inside the legal fill range, let a few spill over
		if (r.operation == OP_PUSH && sb_valid[wr_ptr] && $urandom_range(0, 9) != 0)
			r.operation = OP_POP;
		else if ((r.operation == OP_POP || r.operation == OP_FRONT) && !sb_valid[rd_ptr]
				&& $urandom_range(0, 9) != 0)
			r.operation = OP_PUSH;
		return r;
	endfunction

	task automatic note_error(input string msg);
		error_count++;
		if (error_count <= 10)
			$display("%0t mismatch: %s", $time, msg);
	endtask

	// Hold start until the beat is taken, then record what it should return
	task automatic send_beat(input req_t r);
		start <= 1'b1;
		req_bus <= r;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		pending_rsp.push_back(apply_store_op(r));
		beats_sent++;
	endtask

	task automatic idle_gap();
		if (idle_enable && $urandom_range(0, 3) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 5))
				@(posedge clk);
		end
	endtask

	task automatic wait_drained();
		start <= 1'b0;
		do
			@(posedge clk);
		while (pending_rsp.size() != 0);
	endtask

	always @(posedge clk) begin : check_result
		rsp_t want;
		if (arst_n && done) begin
			results_seen++;
			if (pending_rsp.size() == 0) begin
				note_error($sformatf("unexpected result hit %0b addr %h data %h rob %h",
					result_bus.hit, result_bus.out_address, result_bus.out_data,
					result_bus.out_rob_index));
			end else begin
				want = pending_rsp.pop_front();
				if (result_bus.hit !== want.hit || result_bus.out_address !== want.out_address
						|| result_bus.out_data !== want.out_data
						|| result_bus.out_rob_index !== want.out_rob_index)
					note_error($sformatf(
						"hit %0b/%0b addr %h/%h data %h/%h rob %h/%h (exp/got)",
						want.hit, result_bus.hit, want.out_address, result_bus.out_address,
						want.out_data, result_bus.out_data,
						want.out_rob_index, result_bus.out_rob_index));
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= STALL_LIMIT) begin
			$display("watchdog: no beat for %0d cycles, %0d results outstanding",
				stall_cycles, pending_rsp.size());
			$display("[store_buffer_forwarding_queue] ERROR");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	// Fill every slot first so no later read touches an unwritten entry
	task automatic test_directed_corners();
		logic [31:0] addr;
		logic [31:0] value;
		for (int k = 0; k < DEPTH; k++) begin
			addr = $urandom();
			value = 32'hA5A5_0000 + k;
			if (k == 0) begin
				addr = 32'h0000_0000;
				value = 32'h0000_0000;
			end else if (k == 1) begin
				addr = 32'hFFFF_FFFF;
				value = 32'hFFFF_FFFF;
			end else if (k == 3) begin
				addr = 32'h0000_1000;
			end else if (k == 9) begin
				addr = 32'h0000_1003;
			end
			send_beat(make_req(OP_PUSH, addr, value, k[3:0]));
			idle_gap();
		end
		// full, pointers equal: every slot lies in the walk, youngest alias wins
		send_beat(make_req(OP_QUERY, 32'h0000_1002, '0, '0));
		send_beat(make_req(OP_FRONT, '1, '1, '1));
		// push over a full buffer overwrites the head
		send_beat(make_req(OP_PUSH, 32'h0000_1001, 32'h5A5A_F00D, 4'hF));
		send_beat(make_req(OP_QUERY, 32'h0000_1000, '0, '0));
		// valid slot outside the walk must not match
		send_beat(make_req(OP_QUERY, 32'hFFFF_FFFC, '0, '0));
		send_beat(make_req(OP_POP, '0, '0, '0));
		send_beat(make_req(OP_QUERY, 32'hFFFF_FFFE, '0, '0));
		send_beat(make_req(OP_FLUSH, '1, '1, '1));
		send_beat(make_req(OP_QUERY, 32'h0000_1000, '0, '0));
		send_beat(make_req(OP_POP, '0, '0, '0));
		send_beat(make_req(OP_FRONT, '0, '0, '0));
		for (int k = OP_SPARE_FIRST; k <= OP_SPARE_LAST; k++) begin
			send_beat(make_req(k[2:0], '1, '1, '1));
			idle_gap();
		end
	endtask

	task automatic test_random_mix(input int count);
		for (int n = 0; n < count; n++) begin
			if (n % 40 == 0)
				idle_enable = ($urandom_range(0, 2) != 0);
			send_beat(random_store_op());
			idle_gap();
		end
	endtask

	task automatic test_pause_until_drained();
		idle_enable = 1'b1;
		for (int round = 0; round < 3; round++) begin
			for (int n = 0; n < 8; n++) begin
				send_beat(random_store_op());
				idle_gap();
			end
			wait_drained();
		end
	endtask

	task automatic test_back_to_back(input int count);
		idle_enable = 1'b0;
		for (int n = 0; n < count; n++)
			send_beat(random_store_op());
	endtask

	initial begin
		arst_n <= 1'b0;
		start <= 1'b0;
		req_bus <= '0;
		for (int i = 0; i < DEPTH; i++)
			sb_valid[i] = 1'b0;
		wr_ptr = 0;
		rd_ptr = 0;
		repeat (8)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_corners();
		test_random_mix(400);
		test_pause_until_drained();
		test_back_to_back(250);

		start <= 1'b0;
		while (pending_rsp.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES)
			@(posedge clk);

		$display("%0d commands sent, %0d results checked, %0d mismatches",
			beats_sent, results_seen, error_count);
		$display("forwarding %0d hits / %0d misses, %0d pushes over full, %0d pops of empty",
			query_hits, query_misses, full_pushes, empty_pops);
		if (error_count == 0)
			$display("[store_buffer_forwarding_queue] OK");
		else
			$display("[store_buffer_forwarding_queue] ERROR");
		$finish;
	end

endmodule

`default_nettype wire
